// File: sv/dic_pkg.sv
// Shared types and constants for the distributed illuminance controller.
// No dependencies; used by dic_ctrl, dic_datapath and the top level.
`default_nettype none

package dic_pkg;

    localparam int DIC_MAX_NODES = 8;      // default table depth
    localparam int DIV_BITS      = 15;     // quotient bits below full scale
    localparam int LUX_SHIFT     = 19;     // Q12.4 lux to Q9.23 products

    localparam logic [15:0] FULL_DIM = 16'd32768;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_INTENT = 2'd1,
        OP_LUX    = 2'd2,
        OP_LOAD   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_WAIT      = 3'd0,
        ST_OWN       = 3'd1,
        ST_INTENT    = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_DIST_SET  = 3'd4,
        ST_LOADED    = 3'd5,
        ST_FINISHED  = 3'd6,
        ST_ZERO_GAIN = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_OWN_INDEX  = 2'd1,
        CFG_REFERENCE  = 2'd2,
        CFG_ITER_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op         op;
        logic [7:0]  src_id;
        logic [15:0] value;
        logic [2:0]  entry_index;
        logic [15:0] gain;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [15:0] dimming;
        logic [15:0] disturbance;
        logic [15:0] iteration;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_ACC,
        S_LUX,
        S_DIV_INIT,
        S_DIV_CHK,
        S_DIV_SAT,
        S_DIV_STEP,
        S_SEARCH,
        S_OUT_SEL,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic mul;
        logic acc;
        logic lux;
        logic div_init;
        logic div_chk;
        logic div_sat;
        logic div_step;
        logic search;
        logic out_sel;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic finished;
        logic turn_oor;
        logic turn_zero;
        logic last;
        logic match;
        logic gain_zero;
        logic le0;
        logic sat;
        logic div_last;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// File: sv/dic_ctrl.sv
// Sequencer for the illuminance controller: one item at a time.
// Depends on dic_pkg; drives the command struct into dic_datapath.
`default_nettype none

module dic_ctrl
    import dic_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  t_dp_status i_st,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                unique case (i_st.op)
                    OP_TICK: begin
                        if (!i_st.finished && !i_st.turn_oor && i_st.turn_zero) begin
                            n_state = S_MUL;
                        end else begin
                            n_state = S_OUT_SEL;
                        end
                    end
                    OP_INTENT: n_state = S_SEARCH;
                    OP_LUX:    n_state = S_MUL;
                    OP_LOAD:   n_state = S_OUT_SEL;
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!i_st.last) begin
                    n_state = S_MUL;
                end else if (i_st.op == OP_LUX) begin
                    n_state = S_LUX;
                end else begin
                    n_state = S_DIV_INIT;
                end
            end
            S_LUX: begin
                o_cmd.lux = 1'b1;
                n_state   = S_OUT_SEL;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV_CHK;
            end
            S_DIV_CHK: begin
                o_cmd.div_chk = 1'b1;
                if (i_st.gain_zero || i_st.le0) begin
                    n_state = S_OUT_SEL;
                end else begin
                    n_state = S_DIV_SAT;
                end
            end
            S_DIV_SAT: begin
                o_cmd.div_sat = 1'b1;
                n_state       = i_st.sat ? S_OUT_SEL : S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_OUT_SEL;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_st.match || i_st.last) begin
                    n_state = S_OUT_SEL;
                end
            end
            S_OUT_SEL: begin
                o_cmd.out_sel = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!i_st.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/dic_datapath.sv
// Datapath: config registers, node tables, MAC accumulator, serial divider
// and the output register. Depends on dic_pkg; commanded by dic_ctrl.
`default_nettype none

module dic_datapath
    import dic_pkg::*;
#(
    parameter int MAX_NODE_COUNT = DIC_MAX_NODES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data,
    input  t_in_beat    i_in_data,
    input  t_cmd        i_cmd,
    input  wire         i_out_stall,
    output t_dp_status  o_st,
    output logic        o_out_valid,
    output t_out_beat   o_out_data
);

    localparam int IDX_W  = $clog2(MAX_NODE_COUNT);
    localparam int CNT_W  = $clog2(MAX_NODE_COUNT + 1);
    localparam int TURN_W = (IDX_W > 3) ? IDX_W : 3;
    localparam int ACC_W  = 36 + IDX_W;
    localparam int NUM_W  = 16 + LUX_SHIFT;

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODE_COUNT);

    // configuration
    logic [3:0]  r_node_count;
    logic [2:0]  r_own_index;
    logic [15:0] r_reference;
    logic [15:0] r_limit;

    // state
    logic [7:0]        r_id   [MAX_NODE_COUNT];
    logic [15:0]       r_gain [MAX_NODE_COUNT];
    logic [15:0]       r_dim  [MAX_NODE_COUNT];
    logic [15:0]       r_dist;
    logic [TURN_W-1:0] r_turn;
    logic [15:0]       r_iter;

    // work registers
    t_in_beat          r_item;
    t_status           r_status;
    logic [IDX_W-1:0]  r_j;
    logic [31:0]       r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [15:0]       r_own_gain;
    logic [NUM_W-1:0]  r_num;
    logic [DIV_BITS+15:0] r_rem;
    logic [DIV_BITS+14:0] r_div;
    logic [DIV_BITS-1:0]  r_q;
    logic [3:0]        r_k;

    logic [CNT_W-1:0]  n_eff;
    logic [IDX_W-1:0]  n_m1;
    logic [IDX_W-1:0]  own_p;
    logic [15:0]       rd_gain;
    logic [15:0]       rd_dim;
    logic [7:0]        rd_id;
    logic [ACC_W-1:0]  pos;
    logic [ACC_W-1:0]  diff;
    logic              rem_ge;
    logic [DIV_BITS-1:0] q_next;
    logic [15:0]       tot;
    logic [15:0]       intent_dim;
    logic              dim_we;
    logic [IDX_W-1:0]  dim_wa;
    logic [15:0]       dim_wd;

    always_comb begin
        if (r_node_count == 4'd0) begin
            n_eff = CNT_W'(1);
        end else if (int'(r_node_count) > MAX_NODE_COUNT) begin
            n_eff = MAX_N;
        end else begin
            n_eff = CNT_W'(r_node_count);
        end
    end

    assign n_m1  = IDX_W'(n_eff - CNT_W'(1));
    assign own_p = (int'(r_own_index) < int'(n_eff)) ? IDX_W'(r_own_index) : n_m1;

    assign rd_gain = r_gain[r_j];
    assign rd_dim  = r_dim[r_j];
    assign rd_id   = r_id[r_j];

    assign pos    = ACC_W'({r_reference, {LUX_SHIFT{1'b0}}});
    assign diff   = pos - r_acc;
    assign rem_ge = (r_rem >= {1'b0, r_div});
    assign q_next = {r_q[DIV_BITS-2:0], rem_ge};
    assign tot    = (|r_acc[ACC_W-1:NUM_W]) ? 16'hFFFF : r_acc[NUM_W-1:LUX_SHIFT];
    assign intent_dim = (r_item.value > FULL_DIM) ? FULL_DIM : r_item.value;

    always_comb begin
        o_st.op        = r_item.op;
        o_st.finished  = (r_iter > r_limit);
        o_st.turn_oor  = (int'(r_turn) >= int'(n_eff));
        o_st.turn_zero = (r_turn == '0);
        o_st.last      = (r_j == n_m1);
        o_st.match     = (rd_id == r_item.src_id);
        o_st.gain_zero = (r_own_gain == 16'd0);
        o_st.le0       = (pos <= r_acc);
        o_st.sat       = (r_num[NUM_W-1:DIV_BITS] >= {4'd0, r_own_gain});
        o_st.div_last  = (r_k == 4'(DIV_BITS - 1));
        o_st.out_busy  = o_out_valid && i_out_stall;
    end

    // single write port into the dimming table
    always_comb begin
        dim_we = 1'b0;
        dim_wa = own_p;
        dim_wd = 16'd0;
        if (i_cmd.div_chk && !o_st.gain_zero && o_st.le0) begin
            dim_we = 1'b1;
        end else if (i_cmd.div_sat && o_st.sat) begin
            dim_we = 1'b1;
            dim_wd = FULL_DIM;
        end else if (i_cmd.div_step && o_st.div_last) begin
            dim_we = 1'b1;
            dim_wd = {1'b0, q_next};
        end else if (i_cmd.search && o_st.match) begin
            dim_we = 1'b1;
            dim_wa = r_j;
            dim_wd = intent_dim;
        end
    end

    // control state, config and dimming table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 4'd1;
            r_own_index  <= 3'd0;
            r_reference  <= 16'd0;
            r_limit      <= 16'd1000;
            r_dist       <= 16'd0;
            r_turn       <= '0;
            r_iter       <= 16'd0;
            o_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_NODE_COUNT; i++) begin
                r_dim[i] <= 16'd0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data[3:0];
                    CFG_OWN_INDEX: begin
                        r_own_index <= i_cfg_data[2:0];
                        r_turn      <= TURN_W'(i_cfg_data[2:0]);
                    end
                    CFG_REFERENCE:  r_reference <= i_cfg_data;
                    CFG_ITER_LIMIT: r_limit     <= i_cfg_data;
                endcase
            end
            if (i_cmd.decode && r_item.op == OP_TICK && !o_st.finished) begin
                if (r_iter != 16'hFFFF) begin
                    r_iter <= r_iter + 16'd1;
                end
                if (o_st.turn_oor || o_st.turn_zero) begin
                    r_turn <= TURN_W'(n_m1);
                end else begin
                    r_turn <= r_turn - TURN_W'(1);
                end
            end
            if (i_cmd.lux) begin
                r_dist <= (r_item.value > tot) ? (r_item.value - tot) : 16'd0;
            end
            if (dim_we) begin
                r_dim[dim_wa] <= dim_wd;
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload: tables loaded by op 3, item, MAC and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.decode) begin
            r_acc <= '0;
            r_j   <= '0;
            unique case (r_item.op)
                OP_TICK:   r_status <= o_st.finished ? ST_FINISHED : ST_WAIT;
                OP_INTENT: r_status <= ST_UNKNOWN;
                OP_LUX:    r_status <= ST_DIST_SET;
                OP_LOAD: begin
                    r_status <= ST_LOADED;
                    if (int'(r_item.entry_index) < MAX_NODE_COUNT) begin
                        r_id[IDX_W'(r_item.entry_index)]   <= r_item.src_id;
                        r_gain[IDX_W'(r_item.entry_index)] <= r_item.gain;
                    end
                end
            endcase
        end
        if (i_cmd.mul) begin
            // own term is left out of the neighbour sum on a tick
            if (r_item.op == OP_TICK && r_j == own_p) begin
                r_prod <= 32'd0;
            end else begin
                r_prod <= {16'd0, rd_gain} * {16'd0, rd_dim};
            end
            if (r_j == own_p) begin
                r_own_gain <= rd_gain;
            end
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + ACC_W'(r_prod);
            if (!o_st.last) begin
                r_j <= r_j + IDX_W'(1);
            end
        end
        if (i_cmd.div_init) begin
            r_acc <= r_acc + ACC_W'({r_dist, {LUX_SHIFT{1'b0}}});
        end
        if (i_cmd.div_chk) begin
            r_status <= o_st.gain_zero ? ST_ZERO_GAIN : ST_OWN;
            r_num    <= diff[NUM_W-1:0];
        end
        if (i_cmd.div_sat) begin
            r_rem <= r_num[DIV_BITS+15:0];
            r_div <= {r_own_gain, {(DIV_BITS-1){1'b0}}};
            r_q   <= '0;
            r_k   <= 4'd0;
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - {1'b0, r_div};
            end
            r_div <= r_div >> 1;
            r_q   <= q_next;
            r_k   <= r_k + 4'd1;
        end
        if (i_cmd.search) begin
            if (o_st.match) begin
                r_status <= ST_INTENT;
            end else if (!o_st.last) begin
                r_j <= r_j + IDX_W'(1);
            end
        end
        if (i_cmd.out_sel) begin
            r_j <= own_p;
        end
        if (i_cmd.out_load) begin
            o_out_data.status      <= r_status;
            o_out_data.dimming     <= rd_dim;
            o_out_data.disturbance <= r_dist;
            o_out_data.iteration   <= r_iter;
        end
    end

endmodule

`default_nettype wire

// File: sv/distributed_illuminance_controller.sv
// Top level of one distributed illuminance controller node.
// Depends on dic_pkg, dic_ctrl and dic_datapath.
`default_nettype none

// One node of a round-robin (Gauss-Seidel) lighting control loop. Each input
// beat is an operation: tick, neighbour intent, lux measurement or table
// load; each produces exactly one result beat with a status code, the own
// dimming level (Q1.15), the disturbance estimate (Q12.4) and the tick count.
// Items are handled one at a time; i_in_data is taken in the idle state and
// o_in_stall stays high until the result is in the output register, which
// may still be waiting on i_out_stall while the next item is accepted.
// Steps per item: a table load and a plain or finished tick go straight to
// the output select; an intent searches the table entry by entry until an
// id matches or the last entry is tried; a lux measurement makes a multiply
// and an accumulate step per table entry; an own-turn tick makes the same
// sequential MAC pass and then runs the restoring divider, which is skipped
// for a zero own gain or a non-positive numerator and cut short at full scale.
// A result still held by i_out_stall keeps the node in its finish state.
// Config writes (index, 16-bit data) are always ready and must only be
// issued while the node is idle. Node id and gain entries must be loaded
// before they are used.
module distributed_illuminance_controller
    import dic_pkg::*;
#(
    parameter int MAX_NODE_COUNT = DIC_MAX_NODES
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_beat  o_out_data,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [1:0]  i_cfg_index,
    input  wire [15:0] i_cfg_data
);

    t_cmd       cmd;
    t_dp_status st;

    assign o_cfg_ready = 1'b1;

    dic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dic_datapath #(
        .MAX_NODE_COUNT (MAX_NODE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted beat blocks the input until its result is out
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // the sequencer issues at most one command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // a result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten");

    // dimming never exceeds full scale
    a_dim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.dimming <= FULL_DIM))
        else $error("dimming above full scale");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the distributed illuminance controller node.
// Depends on dic_pkg and distributed_illuminance_controller; needs nothing else.
`default_nettype none

module testbench;
    import dic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 325;
    localparam int NUM_PHASES      = 6;
    localparam int STALL_LIMIT     = 5000;  // cycles with no beat moving anywhere
    localparam int DRAIN_CYCLES    = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_beat    in_beat = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    wire         in_stall;
    wire         out_valid;
    wire         cfg_ready;
    t_out_beat   out_beat;

    distributed_illuminance_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Node model: our own copy of the tables, estimate, turn and count,
    // plus the register settings, updated in accept order.
    // ------------------------------------------------------------------
    logic [7:0]  peer_ids [8];
    logic [15:0] gains    [8];
    logic [15:0] dims     [8];
    logic [15:0] dist_est;
    logic [15:0] tick_cnt;
    int unsigned turn;
    logic [3:0]  reg_nodes;
    logic [2:0]  reg_own;
    logic [15:0] reg_ref;
    logic [15:0] reg_limit;

    t_out_beat   pending_results[$];   // results owed by the block, oldest first
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    bit          status_seen[8];
    int          snd_idle_pct = 0;     // sender gap chance per cycle, percent
    int          rcv_idle_pct = 0;     // receiver stall chance per cycle, percent

    function automatic int unsigned active_nodes();
        if (reg_nodes == 0) return 1;
        if (reg_nodes > 8) return 8;
        return reg_nodes;
    endfunction

    function automatic int unsigned own_slot(int unsigned n);
        return (reg_own < n) ? reg_own : n - 1;
    endfunction

    // Light contributed by table slots below n, Q9.23, optionally skipping one.
    function automatic longint unsigned coupled_light(int unsigned n, int unsigned skip);
        longint unsigned acc;
        acc = 0;
        for (int unsigned j = 0; j < n; j++) begin
            if (j != skip) acc += 64'(gains[j]) * 64'(dims[j]);
        end
        return acc;
    endfunction

    // Apply one input beat to the node model and return the result beat.
    function automatic t_out_beat node_step(t_in_beat b);
        int unsigned     n, p;
        longint unsigned pos, neg, q, tot;
        t_out_beat       r;
        n = active_nodes();
        p = own_slot(n);
        r = '0;
        r.status = ST_WAIT;
        case (b.op)
            OP_TICK: begin
                if (tick_cnt > reg_limit) begin
                    r.status = ST_FINISHED;
                end else begin
                    if (tick_cnt != 16'hFFFF) tick_cnt++;
                    if (turn >= n) begin
                        turn = n - 1;       // stale turn counter, just resync
                    end else if (turn == 0) begin
                        turn = n - 1;
                        if (gains[p] == 0) begin
                            r.status = ST_ZERO_GAIN;
                        end else begin
                            r.status = ST_OWN;
                            pos = 64'(reg_ref) << LUX_SHIFT;
                            neg = (64'(dist_est) << LUX_SHIFT) + coupled_light(n, p);
                            if (pos <= neg) begin
                                dims[p] = '0;
                            end else begin
                                q = (pos - neg) / 64'(gains[p]);
                                dims[p] = (q > 64'(FULL_DIM)) ? FULL_DIM : q[15:0];
                            end
                        end
                    end else begin
                        turn--;
                    end
                end
            end
            OP_INTENT: begin
                r.status = ST_UNKNOWN;
                for (int unsigned j = 0; j < n; j++) begin
                    if (peer_ids[j] == b.src_id) begin
                        dims[j] = (b.value > FULL_DIM) ? FULL_DIM : b.value;
                        r.status = ST_INTENT;
                        break;
                    end
                end
            end
            OP_LUX: begin
                tot = coupled_light(n, 8) >> LUX_SHIFT;
                if (tot > 64'hFFFF) tot = 64'hFFFF;
                dist_est = (64'(b.value) > tot) ? b.value - tot[15:0] : '0;
                r.status = ST_DIST_SET;
            end
            default: begin
                peer_ids[b.entry_index] = b.src_id;
                gains[b.entry_index] = b.gain;
                r.status = ST_LOADED;
            end
        endcase
        r.dimming = dims[own_slot(n)];
        r.disturbance = dist_est;
        r.iteration = tick_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker, receiver stall and watchdog
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            beats_out++;
            status_seen[out_beat.status] = 1'b1;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: %p", $time, out_beat);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_beat.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_beat.status);
                    errors++;
                end
                if (out_beat.dimming !== want.dimming) begin
                    $display("%0t: dimming expected %0d actual %0d",
                             $time, want.dimming, out_beat.dimming);
                    errors++;
                end
                if (out_beat.disturbance !== want.disturbance) begin
                    $display("%0t: disturbance expected %0d actual %0d",
                             $time, want.disturbance, out_beat.disturbance);
                    errors++;
                end
                if (out_beat.iteration !== want.iteration) begin
                    $display("%0t: iteration expected %0d actual %0d",
                             $time, want.iteration, out_beat.iteration);
                    errors++;
                end
            end
        end
    end

    // Any beat on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Present one beat (after random gaps) and hold it until accepted.
    // Valid is left high; the caller or the next gap lowers it.
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat typed_res);
        t_out_beat predicted;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predicted = node_step(b);
        pending_results.push_back(typed ? typed_res : predicted);
        beats_in++;
    endtask

    // Hold the sender off until every owed result is back, then let the
    // block finish any internal work before touching registers.
    task automatic drain_node();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; unused upper data bits carry junk on purpose.
    task automatic reg_write(input t_cfg_idx idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_NODE_COUNT: reg_nodes = data[3:0];
            CFG_OWN_INDEX: begin
                reg_own = data[2:0];
                turn = data[2:0];
            end
            CFG_REFERENCE: reg_ref = data;
            default: reg_limit = data;
        endcase
    endtask

    task automatic set_registers(input int nodes, input int own, input int refl, input int lim);
        reg_write(CFG_NODE_COUNT, {12'($urandom), 4'(nodes)});
        reg_write(CFG_OWN_INDEX, {13'($urandom), 3'(own)});
        reg_write(CFG_REFERENCE, 16'(refl));
        reg_write(CFG_ITER_LIMIT, 16'(lim));
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random beat, mostly well formed: intents name known ids, lux stays
    // near reachable levels, loads keep gains mostly nonzero.
    function automatic t_in_beat random_beat();
        t_in_beat    b;
        int unsigned pick, n;
        n = active_nodes();
        b = '0;
        b.src_id = 8'($urandom);
        b.value = 16'($urandom);
        b.entry_index = 3'($urandom);
        b.gain = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 40) begin
            b.op = OP_TICK;
        end else if (pick < 65) begin
            b.op = OP_INTENT;
            if ($urandom_range(9) < 8) b.src_id = peer_ids[$urandom_range(n - 1)];
            if ($urandom_range(9) < 6) b.value = 16'($urandom_range(32768));
        end else if (pick < 80) begin
            b.op = OP_LUX;
            if ($urandom_range(1)) b.value = 16'($urandom_range(4095));
        end else begin
            b.op = OP_LOAD;
            if ($urandom_range(9) == 0) b.gain = '0;
            else if ($urandom_range(1)) b.gain = 16'($urandom_range(1, 1023));
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows: all eight table slots are loaded first, so no later
    // beat can read a slot that was never written.
    // ------------------------------------------------------------------
    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat res;
    } t_row;

    function automatic t_row mk(t_op op, int sid, int val, int idx, int g, bit typed = 0,
                                t_status st = ST_WAIT, int dim = 0, int dst = 0, int it = 0);
        t_row r;
        r.beat.op = op;
        r.beat.src_id = 8'(sid);
        r.beat.value = 16'(val);
        r.beat.entry_index = 3'(idx);
        r.beat.gain = 16'(g);
        r.typed = typed;
        r.res.status = st;
        r.res.dimming = 16'(dim);
        r.res.disturbance = 16'(dst);
        r.res.iteration = 16'(it);
        return r;
    endfunction

    t_row directed[$];

    initial begin
        int phase_nodes [NUM_PHASES];
        int phase_own   [NUM_PHASES];
        int lim;

        phase_nodes = '{8, 1, 15, 0, 5, 8};
        phase_own   = '{7, 3, 0, 5, 2, 4};
        for (int j = 0; j < 8; j++) dims[j] = '0;
        dist_est = '0;
        tick_cnt = '0;
        turn = 0;
        reg_nodes = 4'd1;
        reg_own = '0;
        reg_ref = '0;
        reg_limit = 16'd1000;

        // Table loads just after reset: nothing else has moved yet.
        directed.push_back(mk(OP_LOAD, 0,   0, 0, 0,     1, ST_LOADED));  // own slot, zero gain
        directed.push_back(mk(OP_LOAD, 255, 0, 1, 65535, 1, ST_LOADED));
        directed.push_back(mk(OP_LOAD, 17,  0, 2, 300,   1, ST_LOADED));
        directed.push_back(mk(OP_LOAD, 42,  0, 3, 1,     1, ST_LOADED));
        directed.push_back(mk(OP_LOAD, 17,  0, 4, 512,   1, ST_LOADED));  // duplicate id
        directed.push_back(mk(OP_LOAD, 99,  0, 5, 40000, 1, ST_LOADED));
        directed.push_back(mk(OP_LOAD, 3,   0, 6, 256,   1, ST_LOADED));
        directed.push_back(mk(OP_LOAD, 200, 0, 7, 7,     1, ST_LOADED));
        // Own turn with zero own gain: flagged, dimming kept, count moves.
        directed.push_back(mk(OP_TICK,   0,   0,     0, 0, 1, ST_ZERO_GAIN, 0, 0, 1));
        // Intent above full scale saturates.
        directed.push_back(mk(OP_INTENT, 0,   65535, 0, 0, 1, ST_INTENT, 32768, 0, 1));
        // Id 255 sits beyond the single active slot.
        directed.push_back(mk(OP_INTENT, 255, 0,     0, 0, 1, ST_UNKNOWN, 32768, 0, 1));
        directed.push_back(mk(OP_LUX,    0,   65535, 0, 0, 1, ST_DIST_SET, 32768, 65535, 1));
        directed.push_back(mk(OP_LUX,    0,   0,     0, 0, 1, ST_DIST_SET, 32768, 0, 1));
        directed.push_back(mk(OP_LOAD,   0,   0,     0, 65535, 1, ST_LOADED, 32768, 0, 1));
        // Reference zero: numerator not positive, dimming goes to zero.
        directed.push_back(mk(OP_TICK,   0,   0,     0, 0, 1, ST_OWN, 0, 0, 2));
        directed.push_back(mk(OP_INTENT, 0,   32768, 0, 0));
        directed.push_back(mk(OP_LUX,    0,   65535, 0, 0));
        directed.push_back(mk(OP_INTENT, 0,   0,     0, 0));
        directed.push_back(mk(OP_TICK,   0,   0,     0, 0));
        directed.push_back(mk(OP_LOAD,   0,   0,     0, 1));
        directed.push_back(mk(OP_INTENT, 0,   32769, 0, 0));
        directed.push_back(mk(OP_TICK,   0,   0,     0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 19;
        rcv_idle_pct = 80;
        foreach (directed[k]) send_beat(directed[k].beat, directed[k].typed, directed[k].res);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Sender waits for every owed result before each register change.
            drain_node();
            case (ph)
                0, 2, 5: lim = 65535;
                1:       lim = 1000;
                3:       lim = 0;               // every tick reports finished
                default: lim = tick_cnt + 25;   // runs into the limit mid phase
            endcase
            set_registers(phase_nodes[ph], phase_own[ph],
                          (ph == 0) ? 65535 : (ph == 1) ? 0 : $urandom_range(65535), lim);
            snd_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 80 : 0;
            rcv_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 19 : 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) send_beat(random_beat(), 0, '0);
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d input beats, %0d result beats, %0d register settings",
                 beats_in, beats_out, NUM_PHASES + 1);
        $display("Status codes seen (0..7): %0d%0d%0d%0d%0d%0d%0d%0d, mismatches: %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7], errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
